[hw/rtl/bbr_pkg.sv]
// ----------------------------------------------------------------------------
// bbr_pkg: shared definitions for the 3x3 RGB box blur
// Widths, register codes, job records and the reciprocal table of the divider.
// ----------------------------------------------------------------------------
package bbr_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int CH_W         = 8;
	localparam int PIX_W        = 3 * CH_W;
	localparam int WIDTH_W      = 12;
	localparam int HEIGHT_W     = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int WIDTH_RST    = 640;
	localparam int HEIGHT_RST   = 480;
	localparam int COL_SUM_W    = 10;
	localparam int SUM_W        = 12;
	localparam int CNT_W        = 4;
	localparam int DIV_X_W      = 13;
	localparam int RECIP_W      = 18;
	localparam int RECIP_SHIFT  = 18;
	localparam int FIFO_DEPTH   = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	// one window column: per-channel sum of its in-image taps and their number
	typedef struct packed {
		logic [2:0][COL_SUM_W-1:0] sum;
		logic [1:0]                cnt;
	} col_t;

	// one blurred word before division
	typedef struct packed {
		logic [2:0][SUM_W-1:0] sum;
		logic [CNT_W-1:0]      cnt;
	} res_sum_t;

	// everything one item releases: an inner word, a row-closing word, or both
	typedef struct packed {
		logic     a_vld;
		res_sum_t a;
		logic     b_vld;
		res_sum_t b;
		logic     frame_end;
	} job_t;

	// ceil(2^RECIP_SHIFT / (2*n)) for n = 1..9
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] m;
		m = '0;
		unique case (n)
			4'd1:    m = 18'd131072;
			4'd2:    m = 18'd65536;
			4'd3:    m = 18'd43691;
			4'd4:    m = 18'd32768;
			4'd5:    m = 18'd26215;
			4'd6:    m = 18'd21846;
			4'd7:    m = 18'd18725;
			4'd8:    m = 18'd16384;
			4'd9:    m = 18'd14564;
			default: m = 18'd131072;
		endcase
		return m;
	endfunction

endpackage

[hw/rtl/bbr_ifs.sv]
// ----------------------------------------------------------------------------
// bbr_ifs: channel interfaces of the box blur
// Pixel input, blurred output and register write channels.
// ----------------------------------------------------------------------------
interface bbr_pix_if;
	logic                    valid;
	logic                    ready;
	logic [bbr_pkg::CH_W-1:0] red_in;
	logic [bbr_pkg::CH_W-1:0] green_in;
	logic [bbr_pkg::CH_W-1:0] blue_in;
	logic                    drain;

	modport source (output valid, red_in, green_in, blue_in, drain, input ready);
	modport sink   (input valid, red_in, green_in, blue_in, drain, output ready);
endinterface

interface bbr_res_if;
	logic                    valid;
	logic                    ready;
	logic [bbr_pkg::CH_W-1:0] red_out;
	logic [bbr_pkg::CH_W-1:0] green_out;
	logic [bbr_pkg::CH_W-1:0] blue_out;
	logic                    row_end;
	logic                    frame_end;

	modport source (output valid, red_out, green_out, blue_out, row_end, frame_end,
		input ready);
	modport sink   (input valid, red_out, green_out, blue_out, row_end, frame_end,
		output ready);
endinterface

interface bbr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bbr_pkg::CFG_IDX_W-1:0]  index;
	logic [bbr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/bbr_front.sv]
// ----------------------------------------------------------------------------
// bbr_front: raster tracking, line store and window
// Takes pixel words, keeps two rows in the line store, builds column sums
// and hands the sums each word releases to the job queue.
// ----------------------------------------------------------------------------
module bbr_front #(
	parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	bbr_pix_if.sink       pix,
	bbr_cfg_if.sink       cfg,
	output logic          push,
	output bbr_pkg::job_t job,
	input  logic          full
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = bbr_pkg::PIX_W;
	localparam int CW = bbr_pkg::CH_W;

	logic [bbr_pkg::WIDTH_W-1:0]  width_q;
	logic [bbr_pkg::HEIGHT_W-1:0] height_q;
	logic [AW-1:0]                col_q;
	logic [bbr_pkg::HEIGHT_W-1:0] row_q;

	logic [AW-1:0]                last_col;
	logic [bbr_pkg::HEIGHT_W-1:0] h_eff;
	logic                         drain_row;
	logic                         take;
	logic                         s1_adv;

	// upper row in the top half, lower row in the bottom half
	logic [2*PW-1:0] line_mem [MAX_WIDTH];

	logic            s1_vld_q;
	logic [PW-1:0]   px_s1;
	logic [AW-1:0]   addr_s1;
	logic            r_ge1_s1;
	logic            r_ge2_s1;
	logic            drain_s1;
	logic            c_ge1_s1;
	logic            c_ge2_s1;
	logic            c_last_s1;
	logic            byp_s1;
	logic [2*PW-1:0] byp_data_s1;
	logic [2*PW-1:0] rd_s1;

	bbr_pkg::col_t   wa_q;
	bbr_pkg::col_t   wb_q;
	bbr_pkg::col_t   new_col;

	logic [PW-1:0]   top;
	logic [PW-1:0]   mid;
	logic [2*PW-1:0] wr_data;

	always_comb begin
		if (width_q == '0) begin
			last_col = '0;
		end else if (32'(width_q) > MAX_WIDTH) begin
			last_col = AW'(MAX_WIDTH - 1);
		end else begin
			last_col = AW'(width_q - 12'd1);
		end
		h_eff = (height_q == '0) ? 13'd1 : height_q;
	end

	assign drain_row = (row_q >= h_eff);
	assign s1_adv    = s1_vld_q && !full;
	assign pix.ready = !s1_vld_q || s1_adv;
	assign cfg.ready = 1'b1;
	// drop a drain word while pixel rows are still expected
	assign take      = pix.valid && pix.ready && (drain_row || !pix.drain);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bbr_pkg::WIDTH_W'(bbr_pkg::WIDTH_RST);
			height_q <= bbr_pkg::HEIGHT_W'(bbr_pkg::HEIGHT_RST);
			col_q    <= '0;
			row_q    <= '0;
			s1_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					bbr_pkg::REG_IMAGE_WIDTH: begin
						width_q <= cfg.data[bbr_pkg::WIDTH_W-1:0];
						col_q   <= '0;
						row_q   <= '0;
					end
					bbr_pkg::REG_IMAGE_HEIGHT: begin
						height_q <= cfg.data[bbr_pkg::HEIGHT_W-1:0];
						col_q    <= '0;
						row_q    <= '0;
					end
					default: ;
				endcase
			end else if (take) begin
				if (col_q == last_col) begin
					col_q <= '0;
					row_q <= drain_row ? '0 : row_q + 13'd1;
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
			if (take) begin
				s1_vld_q <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
		end
	end

	assign top     = byp_s1 ? byp_data_s1[2*PW-1:PW] : rd_s1[2*PW-1:PW];
	assign mid     = byp_s1 ? byp_data_s1[PW-1:0] : rd_s1[PW-1:0];
	assign wr_data = {mid, px_s1};

	always_ff @(posedge clk) begin
		if (take) begin
			rd_s1       <= line_mem[col_q];
			px_s1       <= drain_row ? '0 : {pix.red_in, pix.green_in, pix.blue_in};
			addr_s1     <= col_q;
			r_ge1_s1    <= (row_q != '0);
			r_ge2_s1    <= (row_q >= 13'd2);
			drain_s1    <= drain_row;
			c_ge1_s1    <= (col_q != '0);
			c_ge2_s1    <= (col_q > AW'(1));
			c_last_s1   <= (col_q == last_col);
			// the word ahead writes this address in the same cycle: forward it
			byp_s1      <= s1_adv && (addr_s1 == col_q);
			byp_data_s1 <= wr_data;
		end
		if (s1_adv) begin
			line_mem[addr_s1] <= wr_data;
		end
	end

	always_comb begin
		new_col.cnt = 2'd1 + {1'b0, r_ge2_s1} + {1'b0, !drain_s1};
		for (int k = 0; k < 3; k++) begin
			new_col.sum[k] = (r_ge2_s1 ? 10'(top[CW*(2-k) +: CW]) : 10'd0)
				+ 10'(mid[CW*(2-k) +: CW])
				+ (drain_s1 ? 10'd0 : 10'(px_s1[CW*(2-k) +: CW]));
		end

		job.a_vld     = r_ge1_s1 && c_ge1_s1;
		job.b_vld     = r_ge1_s1 && c_last_s1;
		job.frame_end = drain_s1;
		job.a.cnt = (c_ge2_s1 ? 4'(wa_q.cnt) : 4'd0) + 4'(wb_q.cnt) + 4'(new_col.cnt);
		job.b.cnt = (c_ge1_s1 ? 4'(wb_q.cnt) : 4'd0) + 4'(new_col.cnt);
		for (int k = 0; k < 3; k++) begin
			job.a.sum[k] = (c_ge2_s1 ? 12'(wa_q.sum[k]) : 12'd0)
				+ 12'(wb_q.sum[k]) + 12'(new_col.sum[k]);
			job.b.sum[k] = (c_ge1_s1 ? 12'(wb_q.sum[k]) : 12'd0)
				+ 12'(new_col.sum[k]);
		end
	end

	assign push = s1_adv && (job.a_vld || job.b_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q <= '0;
			wb_q <= '0;
		end else if (s1_adv) begin
			wa_q <= wb_q;
			wb_q <= new_col;
		end
	end

endmodule

[hw/rtl/bbr_fifo.sv]
// ----------------------------------------------------------------------------
// bbr_fifo: job queue
// Short register queue between the window front and the divider back.
// ----------------------------------------------------------------------------
module bbr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bbr_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          vld,
	output bbr_pkg::job_t rdata
);

	localparam int DEPTH = bbr_pkg::FIFO_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	bbr_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]  rd_ptr_q;
	logic [PW-1:0]  wr_ptr_q;
	logic [NW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == NW'(DEPTH));
	assign vld     = (cnt_q != '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[hw/rtl/bbr_back.sv]
// ----------------------------------------------------------------------------
// bbr_back: rounding divider and output register
// Splits each job into its words and divides by reciprocal multiplication.
// ----------------------------------------------------------------------------
module bbr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld,
	input  bbr_pkg::job_t job,
	output logic          pop,
	bbr_res_if.source     res
);

	localparam int XW = bbr_pkg::DIV_X_W;
	localparam int MW = bbr_pkg::RECIP_W;
	localparam int CW = bbr_pkg::CH_W;
	localparam int SH = bbr_pkg::RECIP_SHIFT;

	logic              sel_q;
	logic              s1_vld_q;
	logic              out_vld_q;
	logic              out_free;
	logic              s1_load;
	logic              pick_b;
	bbr_pkg::res_sum_t cur;

	logic [2:0][XW-1:0] x_s1;
	logic [MW-1:0]      m_s1;
	logic               row_end_s1;
	logic               frame_end_s1;

	logic [2:0][XW+MW-1:0] prod;
	logic [2:0][CW-1:0]    chan_q;
	logic                  row_end_q;
	logic                  frame_end_q;

	assign out_free = !out_vld_q || res.ready;
	assign s1_load  = vld && (!s1_vld_q || out_free);
	// inner word first, then the row-closing word of the same job
	assign pick_b   = sel_q || !job.a_vld;
	assign cur      = pick_b ? job.b : job.a;
	assign pop      = s1_load && (pick_b || !job.b_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q     <= 1'b0;
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s1_load) begin
				sel_q <= !pop;
			end
			if (s1_load) begin
				s1_vld_q <= 1'b1;
			end else if (out_free) begin
				s1_vld_q <= 1'b0;
			end
			if (out_free) begin
				out_vld_q <= s1_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			for (int k = 0; k < 3; k++) begin
				x_s1[k] <= XW'({cur.sum[k], 1'b0}) + XW'(cur.cnt);
			end
			m_s1         <= bbr_pkg::recip(cur.cnt);
			row_end_s1   <= pick_b;
			frame_end_s1 <= pick_b && job.frame_end;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = (XW + MW)'(x_s1[k]) * (XW + MW)'(m_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_vld_q) begin
			for (int k = 0; k < 3; k++) begin
				chan_q[k] <= prod[k][SH +: CW];
			end
			row_end_q   <= row_end_s1;
			frame_end_q <= frame_end_s1;
		end
	end

	assign res.valid     = out_vld_q;
	assign res.red_out   = chan_q[0];
	assign res.green_out = chan_q[1];
	assign res.blue_out  = chan_q[2];
	assign res.row_end   = row_end_q;
	assign res.frame_end = frame_end_q;

endmodule

[hw/rtl/box_blur_3x3_rgb.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb: streaming 3x3 box blur of an RGB raster image
// Each output channel is the rounded mean of the in-image 3x3 neighbours.
// ----------------------------------------------------------------------------
// Usage:
//   pix carries one raster pixel per word; after the last row send a row of
//   words with drain set to push out the bottom row. A drain word while pixel
//   rows are still expected is taken and dropped.
//   res carries blurred pixels in raster order, one row and one column behind
//   the input, with row_end and frame_end marking the last of a row / frame.
//   cfg writes image_width (index 0) and image_height (index 1); write only
//   while idle. A write restarts the frame position.
// Timing:
//   One word accepted per cycle while the job queue has room. A released pixel
//   passes the line store read, the job queue, the divider operand stage and
//   the multiply into the output register. The last word of a row releases
//   two pixels, which leave one after the other, inner pixel first.
// Reset:
//   Returns to 640 x 480 and the start of a frame; the line store needs no
//   clearing. When res stalls, the four-entry job queue fills and then pix
//   ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
	parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	bbr_pix_if.sink    pix,
	bbr_res_if.source  res,
	bbr_cfg_if.sink    cfg
);

	logic          push;
	logic          full;
	logic          pop;
	logic          job_vld;
	bbr_pkg::job_t job_in;
	bbr_pkg::job_t job_out;

	bbr_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.cfg    (cfg),
		.push   (push),
		.job    (job_in),
		.full   (full)
	);

	bbr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.full   (full),
		.pop    (pop),
		.vld    (job_vld),
		.rdata  (job_out)
	);

	bbr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (job_vld),
		.job    (job_out),
		.pop    (pop),
		.res    (res)
	);

endmodule

[tb/tb_box_blur_3x3_rgb.sv]
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb: self-checking bench for the streaming 3x3 RGB box blur
// Streams raster frames of many sizes through the pixel channel, predicts every
// blurred word in a software copy of the window and line stores, and checks
// the output stream in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb;

	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MAX_REPORTS     = 20;
	localparam int LOOP_ITEMS      = 1250;

	typedef logic [bbr_pkg::PIX_W-1:0] rgb_t;

	typedef struct packed {
		logic [bbr_pkg::CH_W-1:0] red;
		logic [bbr_pkg::CH_W-1:0] green;
		logic [bbr_pkg::CH_W-1:0] blue;
		logic                     row_end;
		logic                     frame_end;
	} blurred_px_t;

	class box_blur_tracker;
		rgb_t                         upper_row [bbr_pkg::MAX_WIDTH];
		rgb_t                         lower_row [bbr_pkg::MAX_WIDTH];
		rgb_t                         taps [3][3]; // [column oldest..newest][row top..bottom]
		int unsigned                  col_pos;
		int unsigned                  row_pos;
		logic [bbr_pkg::WIDTH_W-1:0]  width_reg;
		logic [bbr_pkg::HEIGHT_W-1:0] height_reg;
		blurred_px_t                  awaited [$];
		int                           mismatches;
		int                           matched;

		function new();
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				lower_row[i] = '0;
			end
			foreach (taps[i, j]) taps[i][j] = '0;
			col_pos    = 0;
			row_pos    = 0;
			width_reg  = bbr_pkg::WIDTH_W'(bbr_pkg::WIDTH_RST);
			height_reg = bbr_pkg::HEIGHT_W'(bbr_pkg::HEIGHT_RST);
			mismatches = 0;
			matched    = 0;
		endfunction

		function int unsigned frame_width();
			if (width_reg == 0) return 1;
			if (32'(width_reg) > bbr_pkg::MAX_WIDTH) return bbr_pkg::MAX_WIDTH;
			return 32'(width_reg);
		endfunction

		function int unsigned frame_height();
			return (height_reg == 0) ? 1 : 32'(height_reg);
		endfunction

		function void write_register(bbr_pkg::cfg_reg_t idx,
				logic [bbr_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				bbr_pkg::REG_IMAGE_WIDTH:  width_reg  = value[bbr_pkg::WIDTH_W-1:0];
				bbr_pkg::REG_IMAGE_HEIGHT: height_reg = value[bbr_pkg::HEIGHT_W-1:0];
				default:                   return;
			endcase
			col_pos = 0;
			row_pos = 0;
		endfunction

		// rounded half-up mean over the enabled taps of columns first_col onwards
		function blurred_px_t window_mean(int unsigned first_col, logic [2:0] col_ok,
				logic [2:0] row_ok, logic last_in_row, logic last_in_frame);
			int unsigned sum [3];
			int unsigned n;
			int unsigned col;
			blurred_px_t px;
			sum = '{0, 0, 0};
			n   = 0;
			for (int i = 0; i < 3; i++) begin
				col = first_col + i;
				if (col_ok[i] && col <= 2) begin
					for (int j = 0; j < 3; j++) begin
						if (row_ok[j]) begin
							for (int k = 0; k < 3; k++) sum[k] += taps[col][j][8*(2-k) +: 8];
							n++;
						end
					end
				end
			end
			px.red       = bbr_pkg::CH_W'((2 * sum[0] + n) / (2 * n));
			px.green     = bbr_pkg::CH_W'((2 * sum[1] + n) / (2 * n));
			px.blue      = bbr_pkg::CH_W'((2 * sum[2] + n) / (2 * n));
			px.row_end   = last_in_row;
			px.frame_end = last_in_frame;
			return px;
		endfunction

		function void take_word(logic [bbr_pkg::CH_W-1:0] r, logic [bbr_pkg::CH_W-1:0] g,
				logic [bbr_pkg::CH_W-1:0] b, logic drain);
			int unsigned w;
			int unsigned h;
			int unsigned c;
			int unsigned row;
			logic        drain_row;
			rgb_t        px;
			rgb_t        top;
			rgb_t        mid;
			logic [2:0]  row_ok;
			w         = frame_width();
			h         = frame_height();
			c         = col_pos;
			row       = row_pos;
			drain_row = (row >= h);
			// drop a drain word while pixel rows are still expected
			if (!drain_row && drain) return;
			if (c >= w) c = w - 1;
			px  = drain_row ? '0 : {r, g, b};
			top = upper_row[c];
			mid = lower_row[c];
			upper_row[c] = mid;
			lower_row[c] = px;
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 3; j++) taps[i][j] = taps[i+1][j];
			taps[2][0] = top;
			taps[2][1] = mid;
			taps[2][2] = px;
			if (row >= 1) begin
				row_ok = {!drain_row, 1'b1, row >= 2};
				if (c >= 1) awaited.push_back(window_mean(0, {1'b1, 1'b1, c >= 2}, row_ok,
					1'b0, 1'b0));
				// last column also closes the row one behind
				if (c == w - 1) awaited.push_back(window_mean(1, {1'b0, 1'b1, c >= 1}, row_ok,
					1'b1, drain_row));
			end
			c++;
			if (c >= w) begin
				c = 0;
				row++;
				if (row > h) row = 0;
			end
			col_pos = c;
			row_pos = row;
		endfunction

		function string describe(blurred_px_t p);
			return $sformatf("r=%0d g=%0d b=%0d re=%0b fe=%0b",
				p.red, p.green, p.blue, p.row_end, p.frame_end);
		endfunction

		function void compare_word(blurred_px_t got);
			blurred_px_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected blurred word: expected none, actual %s",
						$time, describe(got));
				return;
			end
			want = awaited.pop_front();
			if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
					got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: blurred word mismatch: expected %s, actual %s",
						$time, describe(want), describe(got));
			end else begin
				matched++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bbr_pix_if pix();
	bbr_res_if res();
	bbr_cfg_if cfg();

	box_blur_3x3_rgb DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	box_blur_tracker blur_model = new();
	bit              no_idle;
	bit              hold_off_done;
	int              items_sent;
	int              quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		if (no_idle) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [bbr_pkg::CH_W-1:0] random_channel();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15) return '0;
		if (roll < 30) return '1;
		return bbr_pkg::CH_W'($urandom_range(0, 255));
	endfunction

	task automatic send_word(input logic [bbr_pkg::CH_W-1:0] r,
			input logic [bbr_pkg::CH_W-1:0] g, input logic [bbr_pkg::CH_W-1:0] b,
			input logic drain);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid    <= 1'b1;
		pix.red_in   <= r;
		pix.green_in <= g;
		pix.blue_in  <= b;
		pix.drain    <= drain;
		do @(posedge clk); while (pix.ready !== 1'b1);
		blur_model.take_word(r, g, b, drain);
	endtask

	// hold the input until every released word is out and the pipe has settled
	task automatic wait_idle();
		pix.valid <= 1'b0;
		while (blur_model.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input bbr_pkg::cfg_reg_t idx,
			input logic [bbr_pkg::CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		blur_model.write_register(idx, value);
	endtask

	task automatic program_frame(input logic [bbr_pkg::CFG_DATA_W-1:0] w_val,
			input logic [bbr_pkg::CFG_DATA_W-1:0] h_val, input bit set_w, input bit set_h);
		wait_idle();
		if (set_w) write_reg(bbr_pkg::REG_IMAGE_WIDTH, w_val);
		if (set_h) write_reg(bbr_pkg::REG_IMAGE_HEIGHT, h_val);
		cfg.valid <= 1'b0;
	endtask

	// one frame from its start: pixel rows then the drain row; stop early at limit
	task automatic send_frame(input int limit);
		int w;
		int h;
		int n;
		w = blur_model.frame_width();
		h = blur_model.frame_height();
		n = 0;
		for (int row = 0; row <= h; row++) begin
			for (int col = 0; col < w; col++) begin
				if (limit >= 0 && n >= limit) return;
				if (row < h) begin
					if ($urandom_range(0, 99) < 3)
						send_word(random_channel(), random_channel(), random_channel(), 1'b1);
					send_word(random_channel(), random_channel(), random_channel(), 1'b0);
				end else begin
					send_word(random_channel(), random_channel(), random_channel(),
						$urandom_range(0, 3) != 0);
				end
				n++;
				items_sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1)
			blur_model.compare_word({res.red_out, res.green_out, res.blue_out,
				res.row_end, res.frame_end});
	end

	always @(posedge clk) begin
		if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
				(res.valid === 1'b1 && res.ready === 1'b1) ||
				(cfg.valid === 1'b1 && cfg.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// output side: random stalls, plus one long hold-off to back the block up
	initial begin
		int gap;
		res.ready <= 1'b0;
		hold_off_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_off_done && blur_model.matched >= 150) begin
				res.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end
			gap = pick_gap();
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		int                             w;
		int                             h;
		int                             limit;
		int                             room;
		int                             mode;
		bit                             whole;
		logic [bbr_pkg::CFG_DATA_W-1:0] w_val;
		logic [bbr_pkg::CFG_DATA_W-1:0] h_val;
		no_idle      = 1'b0;
		items_sent   = 0;
		quiet_cycles = 0;
		arst_n       <= 1'b0;
		pix.valid    <= 1'b0;
		pix.red_in   <= '0;
		pix.green_in <= '0;
		pix.blue_in  <= '0;
		pix.drain    <= 1'b0;
		cfg.valid    <= 1'b0;
		cfg.index    <= bbr_pkg::REG_IMAGE_WIDTH;
		cfg.data     <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 frame with extreme channels, a stray drain and a pixel in the drain row
		program_frame(16'd3, 16'd3, 1'b1, 1'b1);
		send_word(8'd255, 8'd255, 8'd255, 1'b0);
		send_word(8'd0, 8'd0, 8'd0, 1'b0);
		send_word(8'd255, 8'd0, 8'd128, 1'b0);
		send_word(8'd1, 8'd2, 8'd3, 1'b1);
		send_word(8'd0, 8'd255, 8'd0, 1'b0);
		send_word(8'd255, 8'd255, 8'd255, 1'b0);
		send_word(8'd0, 8'd0, 8'd255, 1'b0);
		send_word(8'd128, 8'd127, 8'd1, 1'b0);
		send_word(8'd254, 8'd1, 8'd255, 1'b0);
		send_word(8'd0, 8'd0, 8'd0, 1'b0);
		send_word(8'd0, 8'd0, 8'd0, 1'b1);
		send_word(8'd255, 8'd255, 8'd255, 1'b0);
		send_word(8'd9, 8'd9, 8'd9, 1'b1);
		// zero sizes act as a single pixel
		program_frame(16'd0, 16'd0, 1'b1, 1'b1);
		send_word(8'd200, 8'd100, 8'd50, 1'b0);
		send_word(8'd0, 8'd0, 8'd0, 1'b1);
		// bits above the register width are dropped: 2x2
		program_frame(16'hF002, 16'hE002, 1'b1, 1'b1);
		send_word(8'd255, 8'd0, 8'd255, 1'b0);
		send_word(8'd0, 8'd255, 8'd0, 1'b0);
		send_word(8'd1, 8'd254, 8'd128, 1'b0);
		send_word(8'd255, 8'd255, 8'd0, 1'b0);
		send_word(8'd0, 8'd0, 8'd0, 1'b1);
		send_word(8'd0, 8'd0, 8'd0, 1'b1);
		whole = 1'b1;

		while (items_sent < LOOP_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if (!whole || $urandom_range(0, 4) != 0) begin
				w_val = ($urandom_range(0, 9) == 0) ?
					bbr_pkg::CFG_DATA_W'($urandom_range(13, 64)) :
					bbr_pkg::CFG_DATA_W'($urandom_range(1, 12));
				h_val = ($urandom_range(0, 9) == 0) ?
					bbr_pkg::CFG_DATA_W'($urandom_range(7, 20)) :
					bbr_pkg::CFG_DATA_W'($urandom_range(1, 6));
				if ($urandom_range(0, 19) == 0) w_val = '0;
				if ($urandom_range(0, 19) == 0) h_val = '0;
				if ($urandom_range(0, 9) == 0)
					w_val = w_val |
						bbr_pkg::CFG_DATA_W'($urandom_range(1, 15) << bbr_pkg::WIDTH_W);
				if ($urandom_range(0, 9) == 0)
					h_val = h_val |
						bbr_pkg::CFG_DATA_W'($urandom_range(1, 7) << bbr_pkg::HEIGHT_W);
				mode = $urandom_range(0, 5);
				// a single-register write still restarts the frame
				program_frame(w_val, h_val, mode != 1 || !whole, mode != 2 || !whole);
			end
			w     = blur_model.frame_width();
			h     = blur_model.frame_height();
			whole = ($urandom_range(0, 9) != 0);
			limit = whole ? -1 : int'($urandom_range(0, w * (h + 1) - 1));
			// keep the last frame from overrunning the item budget
			room = LOOP_ITEMS + 40 - items_sent;
			if (w * (h + 1) > room) begin
				whole = 1'b0;
				if (limit < 0 || limit > room) limit = room;
			end
			send_frame(limit);
		end
		no_idle = 1'b0;

		// largest sizes, cut short by the next write
		program_frame(16'd2048, 16'd4096, 1'b1, 1'b1);
		send_frame(40);
		program_frame(16'd1, 16'd4096, 1'b1, 1'b1);
		send_frame(60);
		program_frame(16'd1, 16'h1FFF, 1'b0, 1'b1);
		send_frame(30);
		program_frame(16'h0FFF, 16'd1, 1'b1, 1'b1);
		send_frame(40);
		program_frame(16'd5, 16'd4, 1'b1, 1'b1);
		send_frame(-1);

		wait_idle();
		if (blur_model.mismatches == 0 && blur_model.awaited.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/bbr_pkg.sv
hw/rtl/bbr_ifs.sv
hw/rtl/bbr_front.sv
hw/rtl/bbr_fifo.sv
hw/rtl/bbr_back.sv
hw/rtl/box_blur_3x3_rgb.sv
tb/tb_box_blur_3x3_rgb.sv
